// ===== rtl/assert_macros.svh =====
// Assertion macros used by the RTL of the metaball field core.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every rising clock edge outside reset.
`define ASSERT_HOLDS(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// Check that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/mfb_pkg.sv =====
// Package for the metaball field core: field widths, codes, table entry type.
// Depends on nothing.
package mfb_pkg;

  localparam int POS_W = 18;
  localparam int RAD_W = 12;
  localparam int VEL_W = 9;
  localparam int PIX_W = 12;
  localparam int ACT_W = 5;
  localparam int SUM_W = 24;
  localparam int FUNC_W = 2;
  localparam int IDX_W = 4;
  localparam int CFG_IDX_W = 2;

  localparam int DEF_MAX_CIRCLES = 16;
  localparam int DEF_SUM_FRACTION_BITS = 16;

  localparam logic [PIX_W-1:0] RST_SCREEN_WIDTH = 12'd1024;
  localparam logic [PIX_W-1:0] RST_SCREEN_HEIGHT = 12'd768;
  localparam logic [ACT_W-1:0] RST_ACTIVE_CIRCLES = 5'd16;

  localparam logic [FUNC_W-1:0] FUNC_LOAD = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_CIRCLES = 2'd2;

  typedef logic signed [POS_W-1:0] pos_t;
  typedef logic [RAD_W-1:0] rad_t;
  typedef logic signed [VEL_W-1:0] vel_t;

  typedef struct packed {
    pos_t cx;
    pos_t cy;
    rad_t r;
    vel_t vx;
    vel_t vy;
  } circ_t;

endpackage

// ===== rtl/metaball_field_bounce_core.sv =====
// Metaball field core: circle table, tick mover and field-sum query engine.
// Depends on mfb_pkg and assert_macros.svh.
//
//  channel   direction  signals                          moves
//  s_*       in         s_tvalid s_tready s_tdata s_tuser one item (load/tick/query)
//  m_*       out        m_tvalid m_tready m_tdata         one result per item
//  cfg_*     in         cfg_valid cfg_ready cfg_index cfg_data  one register write
//
// Sequencing: a tick reads and writes back each active circle in turn; a query
//   reads each active circle in turn (stopping early on saturation) through the
//   shared 18x18 multiplier used three times per circle and the 24-step divider.
// The table is a single-port memory with registered read; valid bits read
//   unwritten entries as zero.
// Reset: synchronous, clears control state and valid bits, loads config defaults; datapath regs are not reset.
// Stalls: s_tready is high only while idle; a finished result waits in the
//   output register and the block accepts the next item meanwhile.
`include "assert_macros.svh"

module metaball_field_bounce_core #(
  parameter int MAX_CIRCLES = mfb_pkg::DEF_MAX_CIRCLES,
  parameter int SUM_FRACTION_BITS = mfb_pkg::DEF_SUM_FRACTION_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // circle_index[3:0] pos_x[21:4] pos_y[39:22] radius_in[51:40]
  // vel_x[60:52] vel_y[69:61], zero fill above
  input  logic [71:0] s_tdata,
  // func[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // inside_res[0] field_sum[24:1], zero fill above
  output logic [31:0] m_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data
);

  localparam int AW = (MAX_CIRCLES > 1) ? $clog2(MAX_CIRCLES) : 1;
  localparam int CNTW = $clog2(MAX_CIRCLES + 1);
  localparam int SUM_W = mfb_pkg::SUM_W;
  localparam int MAG_W = mfb_pkg::POS_W;        // |dx|, |dy| magnitude width
  localparam int PROD_W = 2 * MAG_W;
  localparam int DW = PROD_W + 1;               // squared distance width
  localparam int NW = SUM_W + SUM_FRACTION_BITS; // dividend width
  localparam int HI_W = NW - SUM_W;
  localparam int DCW = $clog2(SUM_W);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_READ = 4'd1;
  localparam logic [3:0] S_MOVE = 4'd2;
  localparam logic [3:0] S_DIFF = 4'd3;
  localparam logic [3:0] S_MULX = 4'd4;
  localparam logic [3:0] S_MULY = 4'd5;
  localparam logic [3:0] S_MULR = 4'd6;
  localparam logic [3:0] S_DIV0 = 4'd7;
  localparam logic [3:0] S_DIV = 4'd8;
  localparam logic [3:0] S_ACC = 4'd9;
  localparam logic [3:0] S_DONE = 4'd10;

  // Input field split
  logic [mfb_pkg::FUNC_W-1:0] func;
  logic [mfb_pkg::IDX_W-1:0] circle_index;
  mfb_pkg::pos_t pos_x, pos_y;
  mfb_pkg::rad_t radius_in;
  mfb_pkg::vel_t vel_x, vel_y;

  assign func = s_tuser;
  assign circle_index = s_tdata[3:0];
  assign pos_x = s_tdata[21:4];
  assign pos_y = s_tdata[39:22];
  assign radius_in = s_tdata[51:40];
  assign vel_x = s_tdata[60:52];
  assign vel_y = s_tdata[69:61];

  // Configuration registers
  logic [mfb_pkg::PIX_W-1:0] screen_width, screen_height;
  logic [mfb_pkg::ACT_W-1:0] active_circles;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width <= mfb_pkg::RST_SCREEN_WIDTH;
      screen_height <= mfb_pkg::RST_SCREEN_HEIGHT;
      active_circles <= mfb_pkg::RST_ACTIVE_CIRCLES;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mfb_pkg::CFG_SCREEN_WIDTH: screen_width <= cfg_data;
        mfb_pkg::CFG_SCREEN_HEIGHT: screen_height <= cfg_data;
        mfb_pkg::CFG_ACTIVE_CIRCLES: active_circles <= cfg_data[mfb_pkg::ACT_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer and datapath registers
  logic [3:0] state;
  logic [CNTW-1:0] cnt, nused;
  logic is_tick;
  mfb_pkg::pos_t qx, qy;
  logic [MAG_W-1:0] adx, ady;
  logic [PROD_W-1:0] prod;
  logic [DW-1:0] d2;
  logic [DW-1:0] rem;
  logic [SUM_W-1:0] lo;
  logic [DCW-1:0] dcnt;
  logic [SUM_W-1:0] sum;
  logic sat;

  // Circle table memory and valid bits
  mfb_pkg::circ_t mem [MAX_CIRCLES];
  logic [MAX_CIRCLES-1:0] vld;
  mfb_pkg::circ_t rd_word;
  logic rd_vld;
  mfb_pkg::circ_t ent;
  logic mem_we;
  logic [AW-1:0] mem_waddr;
  mfb_pkg::circ_t mem_wdata;
  logic [AW-1:0] cnt_addr;

  logic accept;
  logic load_ok;
  logic [CNTW-1:0] nused_next;
  logic [CNTW-1:0] cnt_next;
  logic last;
  mfb_pkg::circ_t moved;

  // Shared multiplier
  logic [MAG_W-1:0] mul_a, mul_b;
  logic [PROD_W-1:0] mul_p;

  // Division helpers
  logic [NW-1:0] num;
  logic [HI_W-1:0] num_hi;
  logic [DW:0] trial;
  logic trial_ge;

  logic signed [mfb_pkg::POS_W:0] dx, dy;
  logic out_free;
  logic in_field;

  function automatic logic past_edge(input mfb_pkg::pos_t c, input mfb_pkg::rad_t r,
                                     input logic [mfb_pkg::PIX_W-1:0] pix);
    logic signed [19:0] twice, hi, rr;
    twice = $signed({c[17], c, 1'b0});
    hi = $signed({3'b000, pix, 5'b00000}) - $signed({8'd0, r});
    rr = $signed({8'd0, r});
    return (twice > hi) || (twice < rr);
  endfunction

  // Negate a velocity; minus the most negative value clips to the top.
  function automatic mfb_pkg::vel_t neg_vel(input mfb_pkg::vel_t v);
    logic signed [9:0] n;
    n = -$signed({v[8], v});
    return (n > 10'sd255) ? 9'sd255 : n[8:0];
  endfunction

  // Add velocity to centre, clip to the position range.
  function automatic mfb_pkg::pos_t step_pos(input mfb_pkg::pos_t c, input mfb_pkg::vel_t v);
    logic [18:0] s;
    s = {c[17], c} + {{10{v[8]}}, v};
    if (s[18] != s[17]) begin
      return s[18] ? {1'b1, 17'd0} : {1'b0, {17{1'b1}}};
    end
    return s[17:0];
  endfunction

  assign s_tready = (state == S_IDLE);
  assign accept = s_tvalid && s_tready;
  assign load_ok = (32'(circle_index) < MAX_CIRCLES);
  assign nused_next = (32'(active_circles) > MAX_CIRCLES) ? CNTW'(MAX_CIRCLES)
                                                          : CNTW'(active_circles);
  assign cnt_addr = cnt[AW-1:0];
  assign cnt_next = cnt + 1'b1;
  assign last = (cnt_next == nused);
  assign ent = rd_vld ? rd_word : '0;

  always_comb begin
    moved = ent;
    if (past_edge(ent.cx, ent.r, screen_width)) begin
      moved.vx = neg_vel(ent.vx);
    end
    if (past_edge(ent.cy, ent.r, screen_height)) begin
      moved.vy = neg_vel(ent.vy);
    end
    moved.cx = step_pos(ent.cx, moved.vx);
    moved.cy = step_pos(ent.cy, moved.vy);
  end

  // One write port: load on accept, write back during a tick
  always_comb begin
    mem_we = 1'b0;
    mem_waddr = cnt_addr;
    mem_wdata = moved;
    if (accept && func == mfb_pkg::FUNC_LOAD && load_ok) begin
      mem_we = 1'b1;
      mem_waddr = AW'(circle_index);
      mem_wdata.cx = pos_x;
      mem_wdata.cy = pos_y;
      mem_wdata.r = radius_in;
      mem_wdata.vx = vel_x;
      mem_wdata.vy = vel_y;
    end else if (state == S_MOVE) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (state == S_READ) begin
      rd_word <= mem[cnt_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (mem_we) begin
        vld[mem_waddr] <= 1'b1;
      end
      if (state == S_READ) begin
        rd_vld <= vld[cnt_addr];
      end
    end
  end

  // Shared multiplier operand select
  always_comb begin
    mul_a = adx;
    mul_b = adx;
    if (state == S_MULY) begin
      mul_a = ady;
      mul_b = ady;
    end else if (state == S_MULR) begin
      mul_a = MAG_W'(ent.r);
      mul_b = MAG_W'(ent.r);
    end
  end
  assign mul_p = mul_a * mul_b;

  assign dx = $signed({qx[17], qx}) - $signed({ent.cx[17], ent.cx});
  assign dy = $signed({qy[17], qy}) - $signed({ent.cy[17], ent.cy});

  assign num = {prod[SUM_W-1:0], {SUM_FRACTION_BITS{1'b0}}};
  assign num_hi = num[NW-1:SUM_W];
  assign trial = {rem, lo[SUM_W-1]};
  assign trial_ge = (trial >= {1'b0, d2});

  assign out_free = !m_tvalid || m_tready;
  assign in_field = sat || ({1'b0, sum} > ((SUM_W + 1)'(1) << SUM_FRACTION_BITS));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      nused <= '0;
      is_tick <= 1'b0;
      sum <= '0;
      sat <= 1'b0;
      dcnt <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // drop valid after the transfer unless a new result loads this cycle
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            sum <= '0;
            sat <= 1'b0;
            cnt <= '0;
            nused <= nused_next;
            is_tick <= (func == mfb_pkg::FUNC_TICK);
            unique case (func) inside
              mfb_pkg::FUNC_TICK, mfb_pkg::FUNC_QUERY: begin
                state <= (nused_next == '0) ? S_DONE : S_READ;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_READ: state <= is_tick ? S_MOVE : S_DIFF;
        S_MOVE: begin
          cnt <= cnt_next;
          state <= last ? S_DONE : S_READ;
        end
        S_DIFF: state <= S_MULX;
        S_MULX: state <= S_MULY;
        S_MULY: state <= S_MULR;
        S_MULR: state <= S_DIV0;
        S_DIV0: begin
          // zero distance or a term of 2^24 or more: saturate and stop
          if (d2 == '0 || DW'(num_hi) >= d2) begin
            sat <= 1'b1;
            state <= S_DONE;
          end else begin
            dcnt <= DCW'(SUM_W - 1);
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (dcnt == '0) begin
            state <= S_ACC;
          end else begin
            dcnt <= dcnt - 1'b1;
          end
        end
        S_ACC: begin
          if (lo > ('1 - sum)) begin
            sat <= 1'b1;
            state <= S_DONE;
          end else begin
            sum <= sum + lo;
            cnt <= cnt_next;
            state <= last ? S_DONE : S_READ;
          end
        end
        S_DONE: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      qx <= pos_x;
      qy <= pos_y;
    end
    if (state == S_DIFF) begin
      adx <= dx[18] ? MAG_W'(-dx) : MAG_W'(dx);
      ady <= dy[18] ? MAG_W'(-dy) : MAG_W'(dy);
    end
    if (state == S_MULX || state == S_MULY || state == S_MULR) begin
      prod <= mul_p;
    end
    if (state == S_MULY) begin
      d2 <= DW'(prod);
    end
    if (state == S_MULR) begin
      d2 <= d2 + DW'(prod);
    end
    if (state == S_DIV0) begin
      rem <= DW'(num_hi);
      lo <= num[SUM_W-1:0];
    end
    if (state == S_DIV) begin
      // restoring step: quotient bit shifts in as dividend bit shifts out
      rem <= trial_ge ? DW'(trial - {1'b0, d2}) : trial[DW-1:0];
      lo <= {lo[SUM_W-2:0], trial_ge};
    end
    if (state == S_DONE && out_free) begin
      m_tdata <= {7'd0, sat ? {SUM_W{1'b1}} : sum, in_field};
    end
  end

  // Remainder stays below the divisor through the whole division
  `ASSERT_IMPL(a_div_rem, clk, rst, state == S_DIV, rem < d2)
  // Table walk never runs past the active count
  `ASSERT_IMPL(a_cnt_range, clk, rst, state == S_READ, cnt < nused)
  // An inside result always carries a nonzero sum
  `ASSERT_IMPL(a_inside_sum, clk, rst, m_tvalid && m_tdata[0], m_tdata[24:1] != '0)

endmodule
